>>> hdl/ellipse_point_generator_defines.svh
// Assertion macros shared by the ellipse point generator checker.
`ifndef ELLIPSE_POINT_GENERATOR_DEFINES_SVH
`define ELLIPSE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define EPG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define EPG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/epg_pkg.sv
// Package for the ellipse point generator: widths, codes, state type and rotation tables.
`timescale 1ns / 1ps

package epg_pkg;

  localparam int MAX_STEPS_DEF = 64;
  localparam int ROM_DEPTH     = 65;
  localparam int STEP_W        = 7;
  localparam int COORD_W       = 32;
  localparam int POINT_W       = 33;
  localparam int MUL_W         = 33;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int THR_W         = 16;
  localparam int SUM_W         = 21;
  localparam int IN_W          = 136;
  localparam int OUT_W         = 72;

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q60    = 64'h1000000000000000;
  localparam logic signed [31:0] ONE_Q30 = 32'sh40000000;
  localparam logic signed [MUL_W-1:0] PI2_Q28 = 33'sd2649351758;
  localparam logic [SUM_W-1:0] SUM_LIMIT = 21'h100000;

  typedef enum logic [1:0] {
    ST_VERTEX,
    ST_BAD_RADIUS,
    ST_EMPTY,
    ST_SATURATED
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AUTO_SUM,
    S_AUTO_MUL,
    S_AUTO_WAIT,
    S_AUTO_RUN,
    S_SETUP,
    S_MX,
    S_MY,
    S_MCC,
    S_MSS,
    S_MSC,
    S_MCS,
    S_ROT,
    S_PUT
  } state_t;

  typedef struct packed {
    logic              done;
    logic [STEP_W-1:0] count;
  } cnt_stat_t;

  typedef logic signed [31:0] rom_t [0:ROM_DEPTH-1];

  // (a * b) >> 60, truncated to 64 bits
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Signed Q60 to Q30, rounding half away from zero
  function automatic logic signed [31:0] q60_to_q30(input logic [63:0] v);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? (64'd0 - v) : v;
    q   = (mag + (64'd1 << 29)) >> 30;
    return v[63] ? 32'(64'd0 - q) : 32'(q);
  endfunction

  // Cosine or sine of 2*pi/n for every n, from a Taylor series in Q60.
  function automatic rom_t rom_build(input logic want_sin);
    rom_t        tab;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] st;
    logic [63:0] ss;
    logic [63:0] ct;
    logic [63:0] cs;
    int          n;
    int          k;
    tab[0] = want_sin ? 32'sd0 : ONE_Q30;
    tab[1] = want_sin ? 32'sd0 : ONE_Q30;
    tab[2] = want_sin ? 32'sd0 : -ONE_Q30;
    for (n = 3; n < ROM_DEPTH; n++) begin
      t  = TWO_PI_Q60 / 64'(n);
      t2 = mul_q60(t, t);
      st = t;
      ss = t;
      ct = ONE_Q60;
      cs = ONE_Q60;
      for (k = 1; k <= 25; k++) begin
        st = mul_q60(st, t2) / 64'((2 * k) * (2 * k + 1));
        ct = mul_q60(ct, t2) / 64'((2 * k - 1) * (2 * k));
        if ((k & 1) != 0) begin
          ss = ss - st;
          cs = cs - ct;
        end else begin
          ss = ss + st;
          cs = cs + ct;
        end
      end
      tab[n] = want_sin ? q60_to_q30(ss) : q60_to_q30(cs);
    end
    return tab;
  endfunction

  localparam rom_t ROM_COS = rom_build(1'b0);
  localparam rom_t ROM_SIN = rom_build(1'b1);

endpackage

>>> hdl/epg_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module epg_mul (
  input  logic                                clk,
  input  logic signed [epg_pkg::MUL_W-1:0]    a,
  input  logic signed [epg_pkg::MUL_W-1:0]    b,
  output logic signed [epg_pkg::PROD_W-1:0]   prod
);
  import epg_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

>>> hdl/epg_autocnt.sv
// Automatic vertex count: steps k upward while (k+1)^2 stays within the threshold.
`timescale 1ns / 1ps

module epg_autocnt #(
  parameter int MAX_STEPS = epg_pkg::MAX_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [epg_pkg::THR_W-1:0]   thr,
  output epg_pkg::cnt_stat_t          stat
);
  import epg_pkg::*;

  localparam int SQ_W = $clog2((MAX_STEPS + 2) * (MAX_STEPS + 2) + 1);
  localparam int CW   = (SQ_W > THR_W) ? SQ_W : THR_W;

  logic              busy;
  logic [STEP_W-1:0] k;
  logic [SQ_W-1:0]   sq;
  logic [THR_W-1:0]  thr_q;
  logic              step_ok;

  // sq always holds (k+1)^2
  assign step_ok = (k < STEP_W'(MAX_STEPS + 1)) && (CW'(sq) <= CW'(thr_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && !step_ok) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k     <= '0;
      sq    <= SQ_W'(1);
      thr_q <= thr;
    end else if (busy && step_ok) begin
      k  <= k + 1'b1;
      sq <= sq + SQ_W'(2 * int'(k) + 3);
    end
  end

  assign stat.done  = busy && !step_ok;
  assign stat.count = k;

endmodule

>>> hdl/ellipse_point_generator.sv
// Top level of the ellipse point generator: sequencer, datapath and output register.
// An item with an explicit count gives its vertices one after another, each from six products
// on the one multiplier; a stalled output register holds up the next. An automatic count first
// passes S_AUTO_SUM to S_AUTO_RUN, stepping once per counted vertex (at most MAX_STEPS + 1).
// A rejected item goes straight to S_PUT for its single result, an empty one by way of S_SETUP.
// Synchronous reset clears the sequencer and the output valid; the block then waits idle.
`timescale 1ns / 1ps

module ellipse_point_generator #(
  parameter int MAX_STEPS = epg_pkg::MAX_STEPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // centre x [31:0], centre y [63:32], x radius [95:64], y radius [127:96],
  // step_count [134:128], zero pad [135]
  input  logic [epg_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // point_x [32:0], point_y [65:33], zero pad [71:66]
  output logic [epg_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tlast,
  // status [1:0]
  output logic [1:0]                 m_tuser
);
  import epg_pkg::*;

  // Input fields as they sit on the slave-side data bus.
  logic signed [COORD_W-1:0] in_ctr_x;
  logic signed [COORD_W-1:0] in_ctr_y;
  logic [COORD_W-1:0]        in_rad_x;
  logic [COORD_W-1:0]        in_rad_y;
  logic [STEP_W-1:0]         in_step_count;

  assign in_ctr_x      = s_tdata[31:0];
  assign in_ctr_y      = s_tdata[63:32];
  assign in_rad_x      = s_tdata[95:64];
  assign in_rad_y      = s_tdata[127:96];
  assign in_step_count = s_tdata[134:128];

  state_t state;
  state_t state_next;

  // Item registers. The y radius is stored already replaced by the x radius when it is zero.
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;
  logic [COORD_W-1:0]        rx;
  logic [COORD_W-1:0]        ry;
  logic [STEP_W-1:0]         n_raw;
  logic [STEP_W-1:0]         n_cnt;
  logic [STEP_W-1:0]         n_eff;
  logic                      sat;
  logic [SUM_W-1:0]          auto_sum;
  logic [COORD_W:0]          radius_sum;

  // Unit vector and rotation step, all Q2.30.
  logic signed [31:0] unit_cos;
  logic signed [31:0] unit_sin;
  logic signed [31:0] rot_cos;
  logic signed [31:0] rot_sin;
  logic signed [31:0] cos_hold;
  logic [STEP_W-1:0]  vertex_index;

  logic signed [PROD_W-1:0] acc;

  // Result waiting to enter the output register.
  logic signed [POINT_W-1:0] res_x;
  logic signed [POINT_W-1:0] res_y;
  logic                      res_last;
  status_t                   res_status;

  // Output register.
  logic signed [POINT_W-1:0] out_x;
  logic signed [POINT_W-1:0] out_y;
  logic                      out_last;
  status_t                   out_status;
  logic                      out_valid;

  logic in_accept;
  logic out_load;
  logic cnt_start;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_q;
  cnt_stat_t                cnt_stat;

  // center + product / 2^38, rounded half away from zero. The sum is split into its floor
  // and fraction; a tie rounds up only when the floor is not negative.
  function automatic logic signed [POINT_W-1:0] vertex_round(
    input logic signed [COORD_W-1:0] center,
    input logic signed [PROD_W-1:0]  p
  );
    logic signed [70:0]        t;
    logic signed [POINT_W-1:0] ip;
    logic [37:0]               f;
    logic                      up;
    t  = (71'(center) <<< 38) + 71'(p);
    ip = t[70:38];
    f  = t[37:0];
    up = ip[POINT_W-1] ? (f > 38'h20_0000_0000) : (f >= 38'h20_0000_0000);
    return ip + POINT_W'(up);
  endfunction

  // v / 2^30 rounded half away from zero, saturated to 32 bits signed.
  function automatic logic signed [31:0] round_q30(input logic signed [PROD_W:0] v);
    logic [PROD_W:0] mag;
    logic [36:0]     q;
    logic            neg;
    neg = v[PROD_W];
    mag = neg ? ((PROD_W + 1)'(0) - v) : v;
    q   = 37'((mag + (PROD_W + 1)'(1 << 29)) >> 30);
    if (!neg && (q > 37'h0_7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (neg && (q > 37'h0_8000_0000)) begin
      return 32'sh8000_0000;
    end else begin
      return neg ? (32'd0 - q[31:0]) : q[31:0];
    end
  endfunction

  assign in_accept  = s_tvalid && s_tready;
  assign radius_sum = {1'b0, rx} + {1'b0, ry};
  assign n_eff      = (n_raw > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : n_raw;

  epg_mul u_epg_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod_q)
  );

  // The automatic count compares (k+1)^2 with pi^2 * sum / 2^9, taken from the product.
  epg_autocnt #(
    .MAX_STEPS (MAX_STEPS)
  ) u_epg_autocnt (
    .clk   (clk),
    .rst   (rst),
    .start (cnt_start),
    .thr   (prod_q[52:37]),
    .stat  (cnt_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake and multiplier operand selection. Each product issued in one
  // state is read back from the multiplier register in the state after it.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    cnt_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (in_rad_x == '0) begin
            state_next = S_PUT;
          end else if (in_step_count <= STEP_W'(2)) begin
            state_next = S_AUTO_SUM;
          end else begin
            state_next = S_SETUP;
          end
        end
      end
      S_AUTO_SUM: begin
        state_next = S_AUTO_MUL;
      end
      S_AUTO_MUL: begin
        mul_a      = PI2_Q28;
        mul_b      = MUL_W'(auto_sum);
        state_next = S_AUTO_WAIT;
      end
      S_AUTO_WAIT: begin
        cnt_start  = 1'b1;
        state_next = S_AUTO_RUN;
      end
      S_AUTO_RUN: begin
        if (cnt_stat.done) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        state_next = (n_raw == '0) ? S_PUT : S_MX;
      end
      S_MX: begin
        mul_a      = {1'b0, rx};
        mul_b      = MUL_W'(unit_cos);
        state_next = S_MY;
      end
      S_MY: begin
        mul_a      = {1'b0, ry};
        mul_b      = MUL_W'(unit_sin);
        state_next = S_MCC;
      end
      S_MCC: begin
        mul_a      = MUL_W'(unit_cos);
        mul_b      = MUL_W'(rot_cos);
        state_next = S_MSS;
      end
      S_MSS: begin
        mul_a      = MUL_W'(unit_sin);
        mul_b      = MUL_W'(rot_sin);
        state_next = S_MSC;
      end
      S_MSC: begin
        mul_a      = MUL_W'(unit_sin);
        mul_b      = MUL_W'(rot_cos);
        state_next = S_MCS;
      end
      S_MCS: begin
        mul_a      = MUL_W'(unit_cos);
        mul_b      = MUL_W'(rot_sin);
        state_next = S_ROT;
      end
      S_ROT: begin
        state_next = S_PUT;
      end
      S_PUT: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = res_last ? S_IDLE : S_MX;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath registers, written according to the sequencer state.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          cx         <= in_ctr_x;
          cy         <= in_ctr_y;
          rx         <= in_rad_x;
          ry         <= (in_rad_y == '0) ? in_rad_x : in_rad_y;
          n_raw      <= in_step_count;
          res_x      <= '0;
          res_y      <= '0;
          res_last   <= 1'b1;
          res_status <= ST_BAD_RADIUS;
        end
      end
      S_AUTO_SUM: begin
        auto_sum <= (radius_sum > (COORD_W + 1)'(SUM_LIMIT)) ? SUM_LIMIT : radius_sum[SUM_W-1:0];
      end
      S_AUTO_RUN: begin
        if (cnt_stat.done) begin
          n_raw <= cnt_stat.count;
        end
      end
      S_SETUP: begin
        n_cnt        <= n_eff;
        sat          <= (n_raw > STEP_W'(MAX_STEPS));
        rot_cos      <= ROM_COS[n_eff];
        rot_sin      <= ROM_SIN[n_eff];
        unit_cos     <= ONE_Q30;
        unit_sin     <= '0;
        vertex_index <= '0;
        res_x        <= '0;
        res_y        <= '0;
        res_last     <= 1'b1;
        res_status   <= ST_EMPTY;
      end
      S_MY: begin
        res_x <= vertex_round(cx, prod_q);
      end
      S_MCC: begin
        res_y      <= vertex_round(cy, prod_q);
        res_last   <= (STEP_W'(vertex_index + 1'b1) == n_cnt);
        res_status <= sat ? ST_SATURATED : ST_VERTEX;
      end
      S_MSS: begin
        acc <= prod_q;
      end
      S_MSC: begin
        // new cosine held back: the old one is still needed for the sine product
        cos_hold <= round_q30((PROD_W + 1)'(acc) - (PROD_W + 1)'(prod_q));
      end
      S_MCS: begin
        acc <= prod_q;
      end
      S_ROT: begin
        unit_sin <= round_q30((PROD_W + 1)'(acc) + (PROD_W + 1)'(prod_q));
        unit_cos <= cos_hold;
      end
      S_PUT: begin
        if (out_load && !res_last) begin
          vertex_index <= vertex_index + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: the sequencer carries on with the next vertex while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x      <= res_x;
      out_y      <= res_y;
      out_last   <= res_last;
      out_status <= res_status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_W - 2 * POINT_W)'(0), out_y, out_x};
  assign m_tlast  = out_last;
  assign m_tuser  = out_status;

endmodule

>>> hdl/epg_checker.sv
// Port-level checker for the ellipse point generator, bound to the top level.
`timescale 1ns / 1ps
`include "ellipse_point_generator_defines.svh"

module epg_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [epg_pkg::IN_W-1:0]   s_tdata,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [epg_pkg::OUT_W-1:0]  m_tdata,
  input logic                       m_tlast,
  input logic [1:0]                 m_tuser
);
  import epg_pkg::*;

  // A stalled result keeps its contents.
  `EPG_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output item changed while stalled")

  // A rejected or empty item gives a single zero result that closes the item.
  `EPG_ASSERT_IMP(a_single_result, m_tvalid && (m_tuser == ST_BAD_RADIUS || m_tuser == ST_EMPTY), m_tlast && (m_tdata == '0), "bad radius or empty result not a lone zero item")

  // One item at a time: no second item straight after an accepted one.
  `EPG_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while an item is at work")

  // When ready for a new item, any result still waiting is the last of its item.
  `EPG_ASSERT_IMP(a_idle_last, s_tready && m_tvalid, m_tlast, "ready while vertices of an item are outstanding")

endmodule

bind ellipse_point_generator epg_checker u_epg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

>>> test/ellipse_vertex_checker.sv
// Checker for the ellipse point generator: predicts each polygon vertex and compares results.
`timescale 1ns / 1ps

module ellipse_vertex_checker #(
  parameter int MAX_STEPS = epg_pkg::MAX_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [epg_pkg::IN_W-1:0]  s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [epg_pkg::OUT_W-1:0] m_tdata,
  input  logic                      m_tlast,
  input  logic [1:0]                m_tuser,
  output int                        open_results,
  output int                        fail_count
);

  localparam logic [63:0]        TWO_PI_FX60 = 64'h6487ED5110B4611A;
  localparam logic [63:0]        ONE_FX60    = 64'h1000000000000000;
  localparam logic signed [31:0] UNIT_Q30    = 32'sh40000000;
  localparam logic [63:0]        PI_SQ_Q28   = 64'd2649351758;
  localparam logic [32:0]        SUM_CAP     = 33'h100000;

  typedef struct packed {
    logic signed [32:0]   x;
    logic signed [32:0]   y;
    logic                 last;
    epg_pkg::status_t     status;
  } vertex_t;

  vertex_t            vertex_q[$];
  vertex_t            exp_v;
  logic signed [31:0] cos_rom [0:64];
  logic signed [31:0] sin_rom [0:64];
  logic signed [31:0] unit_c;
  logic signed [31:0] unit_s;
  int                 vertex_idx;
  int                 polygon_n;
  int                 mismatches;

  function automatic logic [63:0] mul_fx60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    return prod[123:60];
  endfunction

  function automatic logic signed [31:0] fx60_to_q30(input logic [63:0] v);
    logic [63:0] mag;
    mag = v[63] ? (64'd0 - v) : v;
    mag = (mag + (64'd1 << 29)) >> 30;
    return v[63] ? -mag[31:0] : mag[31:0];
  endfunction

  // Cosine and sine of 2*pi/n from 26 Taylor terms in Q60.
  function automatic void trig_for_count(input int n, output logic signed [31:0] c,
                                         output logic signed [31:0] s);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] sin_term;
    logic [63:0] cos_term;
    logic [63:0] sin_acc;
    logic [63:0] cos_acc;
    if (n < 3) begin
      c = (n == 2) ? -UNIT_Q30 : UNIT_Q30;
      s = '0;
      return;
    end
    ang      = TWO_PI_FX60 / 64'(n);
    ang_sq   = mul_fx60(ang, ang);
    sin_term = ang;
    sin_acc  = ang;
    cos_term = ONE_FX60;
    cos_acc  = ONE_FX60;
    for (int k = 1; k <= 25; k++) begin
      sin_term = mul_fx60(sin_term, ang_sq) / 64'((2 * k) * (2 * k + 1));
      cos_term = mul_fx60(cos_term, ang_sq) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        sin_acc = sin_acc - sin_term;
        cos_acc = cos_acc - cos_term;
      end else begin
        sin_acc = sin_acc + sin_term;
        cos_acc = cos_acc + cos_term;
      end
    end
    c = fx60_to_q30(cos_acc);
    s = fx60_to_q30(sin_acc);
  endfunction

  // Rotated component: round half away from zero at bit 30, saturate to 32 bits.
  function automatic logic signed [31:0] rotate_round(input longint v);
    longint unsigned mag;
    longint unsigned q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q   = (mag + (64'd1 << 29)) >> 30;
    if (v >= 0 && q > 64'h7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < 0 && q > 64'h80000000) return 32'sh80000000;
    return (v < 0) ? -q[31:0] : q[31:0];
  endfunction

  // center + radius * unit, held exactly in units of 2^-38, then rounded half away from zero.
  function automatic logic signed [32:0] vertex_coord(input logic [31:0] center,
                                                      input logic [31:0] radius,
                                                      input logic [31:0] unitv);
    logic signed [127:0] acc;
    logic signed [127:0] mag;
    acc = ($signed({{96{center[31]}}, center}) <<< 38)
        + $signed({96'd0, radius}) * $signed({{96{unitv[31]}}, unitv});
    mag = (acc < 0) ? -acc : acc;
    mag = (mag + (128'sd1 <<< 37)) >>> 38;
    mag = (acc < 0) ? -mag : mag;
    return mag[32:0];
  endfunction

  // Vertex count from the radii: floor(pi * sqrt((rx + ry) / 512)), capped at MAX_STEPS + 1.
  function automatic int auto_count(input logic [31:0] rx, input logic [31:0] ry);
    logic [32:0] sum;
    logic [63:0] bound;
    int          n;
    sum = {1'b0, rx} + {1'b0, ry};
    if (sum > SUM_CAP) sum = SUM_CAP;
    bound = PI_SQ_Q28 * 64'(sum);
    n = 0;
    while (n < MAX_STEPS + 1 && ((64'(n + 1) * 64'(n + 1)) << 37) <= bound) n++;
    return n;
  endfunction

  task automatic add_result(input logic signed [32:0] x, input logic signed [32:0] y,
                            input logic last, input epg_pkg::status_t st);
    vertex_t v;
    v.x      = x;
    v.y      = y;
    v.last   = last;
    v.status = st;
    vertex_q = {vertex_q, v};
  endtask

  task automatic predict_polygon(input logic [epg_pkg::IN_W-1:0] item);
    logic [31:0]        cx;
    logic [31:0]        cy;
    logic [31:0]        rx;
    logic [31:0]        ry;
    logic [6:0]         steps;
    logic signed [31:0] rc;
    logic signed [31:0] rs;
    logic signed [31:0] next_c;
    epg_pkg::status_t   st;
    cx    = item[31:0];
    cy    = item[63:32];
    rx    = item[95:64];
    ry    = item[127:96];
    steps = item[134:128];
    if (rx == 0) begin
      add_result('0, '0, 1'b1, epg_pkg::ST_BAD_RADIUS);
      return;
    end
    if (ry == 0) ry = rx;
    polygon_n = (steps <= 2) ? auto_count(rx, ry) : int'(steps);
    st = epg_pkg::ST_VERTEX;
    if (polygon_n > MAX_STEPS) begin
      polygon_n = MAX_STEPS;
      st        = epg_pkg::ST_SATURATED;
    end
    if (polygon_n == 0) begin
      add_result('0, '0, 1'b1, epg_pkg::ST_EMPTY);
      return;
    end
    rc     = cos_rom[polygon_n];
    rs     = sin_rom[polygon_n];
    unit_c = UNIT_Q30;
    unit_s = '0;
    for (vertex_idx = 0; vertex_idx < polygon_n; vertex_idx++) begin
      add_result(vertex_coord(cx, rx, unit_c), vertex_coord(cy, ry, unit_s),
                 vertex_idx + 1 == polygon_n, st);
      next_c = rotate_round(longint'(unit_c) * longint'(rc) - longint'(unit_s) * longint'(rs));
      unit_s = rotate_round(longint'(unit_s) * longint'(rc) + longint'(unit_c) * longint'(rs));
      unit_c = next_c;
    end
  endtask

  initial begin
    mismatches = 0;
    unit_c     = '0;
    unit_s     = '0;
    vertex_idx = 0;
    polygon_n  = 0;
    for (int n = 0; n <= 64; n++) trig_for_count(n, cos_rom[n], sin_rom[n]);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) predict_polygon(s_tdata);
      if (m_tvalid && m_tready) begin
        if (vertex_q.size() == 0) begin
          $error("unexpected result: point_x %0d point_y %0d status %0d",
                 $signed(m_tdata[32:0]), $signed(m_tdata[65:33]), m_tuser);
          mismatches++;
        end else begin
          exp_v = vertex_q.pop_front();
          if (m_tdata[32:0] !== exp_v.x) begin
            $error("point_x: expected %0d, actual %0d", exp_v.x, $signed(m_tdata[32:0]));
            mismatches++;
          end
          if (m_tdata[65:33] !== exp_v.y) begin
            $error("point_y: expected %0d, actual %0d", exp_v.y, $signed(m_tdata[65:33]));
            mismatches++;
          end
          if (m_tlast !== exp_v.last) begin
            $error("last_point: expected %0d, actual %0d", exp_v.last, m_tlast);
            mismatches++;
          end
          if (m_tuser !== exp_v.status) begin
            $error("status: expected %0d, actual %0d", exp_v.status, m_tuser);
            mismatches++;
          end
        end
      end
    end
    open_results <= vertex_q.size();
    fail_count   <= mismatches;
  end

endmodule

>>> test/tb_ellipse_point_generator.sv
// Testbench top for the ellipse point generator: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_ellipse_point_generator;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 50;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [epg_pkg::IN_W-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [epg_pkg::OUT_W-1:0] m_tdata;
  logic                      m_tlast;
  logic [1:0]                m_tuser;
  int                        open_results;
  int                        fail_count;
  int                        quiet_cycles = 0;
  int                        send_idle_pct = 0;
  int                        recv_stall_pct = 0;

  ellipse_point_generator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  ellipse_vertex_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser),
    .open_results (open_results),
    .fail_count   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Any cycle without an item moving on either side counts towards the limit.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_ellipse_point_generator failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [epg_pkg::IN_W-1:0] ellipse_item(input logic [31:0] cx,
                                                           input logic [31:0] cy,
                                                           input logic [31:0] rx,
                                                           input logic [31:0] ry,
                                                           input logic [6:0] steps);
    return {1'b0, steps, ry, rx, cy, cx};
  endfunction

  // Radii are mostly small, so that automatic counts land on every value.
  function automatic logic [31:0] pick_radius(input int zero_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < zero_pct) return '0;
    if (pick < 40) return 32'($urandom_range(600, 1));
    if (pick < 75) return 32'($urandom_range(120000, 1));
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_center();
    if ($urandom_range(9) < 6) return $urandom;
    return 32'($urandom_range(2000)) - 32'd1000;
  endfunction

  function automatic logic [epg_pkg::IN_W-1:0] random_ellipse();
    logic [6:0] steps;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 30) steps = 7'($urandom_range(2));
    else if (pick < 35) steps = 7'($urandom_range(127, 65));
    else if (pick < 70) steps = 7'($urandom_range(16, 3));
    else steps = 7'($urandom_range(64, 3));
    return ellipse_item(pick_center(), pick_center(), pick_radius(5), pick_radius(15), steps);
  endfunction

  // Presents one item and returns at the edge where it is taken.
  task automatic send_item(input logic [epg_pkg::IN_W-1:0] item);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (ITEMS_PER_PHASE) send_item(random_ellipse());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed cases: plain square, rejected radius, copied y radius, automatic counts
    // giving none, one, two, many and saturated, out-of-range counts and extreme fields.
    send_item(ellipse_item(32'd0, 32'd0, 32'd256, 32'd256, 7'd4));
    send_item(ellipse_item(32'd5, 32'd7, 32'd0, 32'd4096, 7'd5));
    send_item(ellipse_item(32'd0, 32'd0, 32'd0, 32'd0, 7'd0));
    send_item(ellipse_item(32'd100, 32'hFFFFFF9C, 32'd1000, 32'd0, 7'd8));
    send_item(ellipse_item(32'd0, 32'd0, 32'd10, 32'd10, 7'd0));
    send_item(ellipse_item(32'd0, 32'd0, 32'd1, 32'd0, 7'd1));
    send_item(ellipse_item(32'd3, 32'd3, 32'd60, 32'd60, 7'd0));
    send_item(ellipse_item(32'hFFFFFFF0, 32'd16, 32'd150, 32'd150, 7'd1));
    send_item(ellipse_item(32'd0, 32'd0, 32'd100000, 32'd100000, 7'd2));
    send_item(ellipse_item(32'd0, 32'd0, 32'h00100000, 32'd7, 7'd2));
    send_item(ellipse_item(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 7'd3));
    send_item(ellipse_item(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'd1, 7'd64));
    send_item(ellipse_item(32'hFFFFFFFF, 32'd0, 32'd1, 32'd1, 7'd3));
    send_item(ellipse_item(32'hFFFFFFFD, 32'd3, 32'd128, 32'd128, 7'd4));
    send_item(ellipse_item(32'd0, 32'd0, 32'd512, 32'd300, 7'd65));
    send_item(ellipse_item(32'h12345678, 32'h9ABCDEF0, 32'd77, 32'd0, 7'd127));
    send_item(ellipse_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 7'd0));
    send_item(ellipse_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h00000100, 7'd6));

    // Random phases: free flow, sender gaps, receiver stalls, then both together.
    run_phase(0, 0);
    run_phase(47, 0);
    run_phase(0, 47);
    run_phase(37, 37);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_ellipse_point_generator passed");
    end else begin
      $display("tb_ellipse_point_generator failed");
    end
    $finish;
  end

endmodule
